@@ design/mmhq_pkg.sv @@
// Shared types and codes for the min-max heap queue.
package mmhq_pkg;

  // Operation codes on the input channel
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP_MIN = 2'd1;
  localparam logic [1:0] OP_POP_MAX = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // Status codes on the result channel
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BU_P,
    ST_BU_G,
    ST_BU_GW,
    ST_PM2,
    ST_PM3,
    ST_PV,
    ST_RM,
    ST_RMX,
    ST_SD,
    ST_SC,
    ST_SDEC,
    ST_SPM,
    ST_WX,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_FIN
  } state_t;

endpackage

@@ design/mmhq_in_if.sv @@
// Input channel: operation and key with valid/ready handshake.
interface mmhq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

@@ design/mmhq_out_if.sv @@
// Result channel: popped key, status, count and extremes with valid/ready handshake.
interface mmhq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] popped_value;
  logic [1:0]  status;
  logic [10:0] element_count;
  logic [31:0] current_min;
  logic [31:0] current_max;

  modport source (output valid, output popped_value, output status, output element_count,
                  output current_min, output current_max, input ready);
  modport sink   (input valid, input popped_value, input status, input element_count,
                  input current_min, input current_max, output ready);
endinterface

@@ design/min_max_heap_queue_unit.sv @@
// Top level of the min-max heap queue: sequencer around one heap memory.
//
// Double-ended priority queue of signed keys held as a min-max heap in one
// CAPACITY-deep RAM with registered reads. Each accepted item is a push,
// pop-min, pop-max or no-op and yields exactly one result carrying the popped
// key, a status, the count and the current min and max. A push into a non-empty
// heap first checks the parent, then climbs one grandparent level per step
// until it stops on a compare or has no grandparent left. A pop-max on three or
// more keys first compares the two children of the root. A pop then descends
// two levels per step: a first read, the child and grandchild reads one per
// cycle, a decide step and a parent fix. The single RAM read port makes this
// work serial; while an earlier result is not taken, the sequencer waits in
// the finish state. One item is worked at a time; the next item is taken as
// soon as the sequencer is back in idle, even if the previous result still
// waits in the output register. No clearing pass is needed after reset: only
// entries below the count are ever used.
module min_max_heap_queue_unit #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  mmhq_in_if.sink    in_ch,
  mmhq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = CNT_W + 3;
  localparam int KIN   = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

  // Candidate index k of node i: two children, then four grandchildren
  function automatic logic [CW-1:0] cand_of(input logic [CW-1:0] i, input logic [2:0] k);
    logic [CW-1:0] r;
    if (k < 3'd2) begin
      r = (i << 1) + CW'(1) + CW'(k);
    end else begin
      r = (i << 2) + CW'(1) + CW'(k);
    end
    return r;
  endfunction

  // True when index i sits on a min level
  function automatic logic on_min_level(input logic [CNT_W-1:0] i);
    logic [CNT_W-1:0] n;
    logic             par;
    n   = i + CNT_W'(1);
    par = 1'b0;
    for (int b = 0; b < CNT_W; b++) begin
      if (n[b]) begin
        par = b[0];
      end
    end
    return !par;
  endfunction

  mmhq_pkg::state_t st_r, st_nxt;

  logic [CNT_W-1:0]     size_r, size_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt;
  logic [IDX_W-1:0]     pm_r, pm_nxt;
  logic [KEY_WIDTH-1:0] x_r, x_nxt;
  logic [KEY_WIDTH-1:0] best_val_r, best_val_nxt;
  logic [CW-1:0]        best_idx_r, best_idx_nxt;
  logic [KEY_WIDTH-1:0] c0_r, c0_nxt;
  logic [KEY_WIDTH-1:0] c1_r, c1_nxt;
  logic [KEY_WIDTH-1:0] hpm_r, hpm_nxt;
  logic [KEY_WIDTH-1:0] popped_r, popped_nxt;
  logic [KEY_WIDTH-1:0] mn_r, mn_nxt;
  logic [KEY_WIDTH-1:0] mx_r, mx_nxt;
  logic [2:0]           k_r, k_nxt;
  logic                 dmin_r, dmin_nxt;
  logic [1:0]           status_r, status_nxt;

  logic                 out_valid_r;
  logic [31:0]          out_popped_r, out_min_r, out_max_r;
  logic [1:0]           out_status_r;
  logic [10:0]          out_count_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [KEY_WIDTH-1:0] ram_wr_data, rd;

  // Shared decode and compare terms
  logic                 accept, out_free;
  logic [KEY_WIDTH-1:0] key;
  logic                 full, empty;
  logic [CW-1:0]        i_w, size_w, c_first, c_next, c_cur, two_i2, pm_w;
  logic                 sc_more, sc_better, dec_child, dec_better, dec_swap;
  logic                 bu_minl, bu_flip, gw_move, last_hit, pm3_pick1;
  logic [KEY_WIDTH-1:0] hpm_sel;
  logic [CNT_W-1:0]     par_of_size, gp_of_i;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign key      = KEY_WIDTH'($signed(in_ch.push_value[KIN-1:0]));
  assign full     = (size_r == CNT_W'(CAPACITY));
  assign empty    = (size_r == '0);

  assign i_w         = CW'(i_r);
  assign size_w      = CW'(size_r);
  assign c_first     = cand_of(i_w, 3'd0);
  assign c_cur       = cand_of(i_w, k_r);
  assign c_next      = cand_of(i_w, k_r + 3'd1);
  assign sc_more     = (k_r < 3'd5) && (c_next < size_w);
  assign sc_better   = dmin_r ? ($signed(rd) < $signed(best_val_r))
                              : ($signed(rd) > $signed(best_val_r));
  assign two_i2      = (i_w << 1) + CW'(2);
  assign dec_child   = (best_idx_r <= two_i2);
  assign dec_better  = dmin_r ? ($signed(best_val_r) < $signed(x_r))
                              : ($signed(best_val_r) > $signed(x_r));
  assign pm_w        = (best_idx_r - CW'(1)) >> 1;
  assign hpm_sel     = (pm_w == c_first) ? c0_r : c1_r;
  assign dec_swap    = dmin_r ? ($signed(x_r) > $signed(hpm_sel))
                              : ($signed(x_r) < $signed(hpm_sel));
  assign bu_minl     = on_min_level(CNT_W'(i_r));
  assign bu_flip     = bu_minl ? ($signed(x_r) > $signed(rd)) : ($signed(x_r) < $signed(rd));
  assign gw_move     = dmin_r ? ($signed(x_r) < $signed(rd)) : ($signed(x_r) > $signed(rd));
  assign gp_of_i     = (CNT_W'(i_r) - CNT_W'(3)) >> 2;
  assign par_of_size = (size_r - CNT_W'(1)) >> 1;
  assign last_hit    = (CNT_W'(i_r) == size_r - CNT_W'(1));
  assign pm3_pick1   = ($signed(best_val_r) > $signed(rd));

  // Heap memory
  mmhq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (rd)
  );

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mmhq_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            mmhq_pkg::OP_PUSH: begin
              if (full) st_nxt = mmhq_pkg::ST_RD0;
              else if (empty) st_nxt = mmhq_pkg::ST_BU_G;
              else st_nxt = mmhq_pkg::ST_BU_P;
            end
            mmhq_pkg::OP_POP_MIN: begin
              st_nxt = empty ? mmhq_pkg::ST_RD0 : mmhq_pkg::ST_PV;
            end
            mmhq_pkg::OP_POP_MAX: begin
              if (empty) st_nxt = mmhq_pkg::ST_RD0;
              else if (size_r <= CNT_W'(2)) st_nxt = mmhq_pkg::ST_PV;
              else st_nxt = mmhq_pkg::ST_PM2;
            end
            default: st_nxt = mmhq_pkg::ST_RD0;
          endcase
        end
      end
      mmhq_pkg::ST_BU_P:  st_nxt = mmhq_pkg::ST_BU_G;
      mmhq_pkg::ST_BU_G:  st_nxt = (i_r >= IDX_W'(3)) ? mmhq_pkg::ST_BU_GW : mmhq_pkg::ST_RD0;
      mmhq_pkg::ST_BU_GW: st_nxt = gw_move ? mmhq_pkg::ST_BU_G : mmhq_pkg::ST_RD0;
      mmhq_pkg::ST_PM2:   st_nxt = mmhq_pkg::ST_PM3;
      mmhq_pkg::ST_PM3:   st_nxt = mmhq_pkg::ST_RM;
      mmhq_pkg::ST_PV:    st_nxt = mmhq_pkg::ST_RM;
      mmhq_pkg::ST_RM:    st_nxt = last_hit ? mmhq_pkg::ST_RD0 : mmhq_pkg::ST_RMX;
      mmhq_pkg::ST_RMX:   st_nxt = mmhq_pkg::ST_SD;
      mmhq_pkg::ST_SD:    st_nxt = (c_first >= size_w) ? mmhq_pkg::ST_RD0 : mmhq_pkg::ST_SC;
      mmhq_pkg::ST_SC:    st_nxt = sc_more ? mmhq_pkg::ST_SC : mmhq_pkg::ST_SDEC;
      mmhq_pkg::ST_SDEC: begin
        if (!dec_better) st_nxt = mmhq_pkg::ST_RD0;
        else if (dec_child) st_nxt = mmhq_pkg::ST_WX;
        else if (dec_swap) st_nxt = mmhq_pkg::ST_SPM;
        else st_nxt = mmhq_pkg::ST_SD;
      end
      mmhq_pkg::ST_SPM:   st_nxt = mmhq_pkg::ST_SD;
      mmhq_pkg::ST_WX:    st_nxt = mmhq_pkg::ST_RD0;
      mmhq_pkg::ST_RD0:   st_nxt = empty ? mmhq_pkg::ST_FIN : mmhq_pkg::ST_RD1;
      mmhq_pkg::ST_RD1:   st_nxt = (size_r >= CNT_W'(2)) ? mmhq_pkg::ST_RD2 : mmhq_pkg::ST_FIN;
      mmhq_pkg::ST_RD2:   st_nxt = (size_r >= CNT_W'(3)) ? mmhq_pkg::ST_RD3 : mmhq_pkg::ST_FIN;
      mmhq_pkg::ST_RD3:   st_nxt = mmhq_pkg::ST_FIN;
      mmhq_pkg::ST_FIN:   st_nxt = out_free ? mmhq_pkg::ST_IDLE : mmhq_pkg::ST_FIN;
      default:            st_nxt = mmhq_pkg::ST_IDLE;
    endcase
  end

  // Memory port and handshake controls
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = i_r;
    ram_wr_data = x_r;
    ram_rd_addr = '0;
    in_ch.ready = (st_r == mmhq_pkg::ST_IDLE);
    unique case (st_r)
      mmhq_pkg::ST_IDLE: begin
        if (in_ch.operation == mmhq_pkg::OP_PUSH) begin
          ram_rd_addr = par_of_size[IDX_W-1:0];
        end else if (in_ch.operation == mmhq_pkg::OP_POP_MAX && size_r != CNT_W'(1)) begin
          ram_rd_addr = IDX_W'(1);
        end
      end
      mmhq_pkg::ST_BU_P: begin
        if (bu_flip) begin
          ram_we      = 1'b1;
          ram_wr_data = rd;
        end
      end
      mmhq_pkg::ST_BU_G: begin
        ram_rd_addr = gp_of_i[IDX_W-1:0];
        ram_we      = (i_r < IDX_W'(3));
      end
      mmhq_pkg::ST_BU_GW: begin
        ram_we = 1'b1;
        if (gw_move) ram_wr_data = rd;
      end
      mmhq_pkg::ST_PM2: ram_rd_addr = IDX_W'(2);
      mmhq_pkg::ST_RM:  ram_rd_addr = IDX_W'(size_r - CNT_W'(1));
      mmhq_pkg::ST_SD: begin
        ram_rd_addr = c_first[IDX_W-1:0];
        ram_we      = (c_first >= size_w);
      end
      mmhq_pkg::ST_SC: ram_rd_addr = c_next[IDX_W-1:0];
      mmhq_pkg::ST_SDEC: begin
        ram_we = 1'b1;
        if (dec_better) ram_wr_data = best_val_r;
      end
      mmhq_pkg::ST_SPM: begin
        ram_we      = 1'b1;
        ram_wr_addr = pm_r;
      end
      mmhq_pkg::ST_WX:  ram_we = 1'b1;
      mmhq_pkg::ST_RD0: ram_rd_addr = '0;
      mmhq_pkg::ST_RD1: ram_rd_addr = IDX_W'(1);
      mmhq_pkg::ST_RD2: ram_rd_addr = IDX_W'(2);
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    size_nxt     = size_r;
    i_nxt        = i_r;
    pm_nxt       = pm_r;
    x_nxt        = x_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    c0_nxt       = c0_r;
    c1_nxt       = c1_r;
    hpm_nxt      = hpm_r;
    popped_nxt   = popped_r;
    mn_nxt       = mn_r;
    mx_nxt       = mx_r;
    k_nxt        = k_r;
    dmin_nxt     = dmin_r;
    status_nxt   = status_r;
    case (st_r)
      mmhq_pkg::ST_IDLE: begin
        if (accept) begin
          popped_nxt = '0;
          status_nxt = mmhq_pkg::STAT_OK;
          dmin_nxt   = (in_ch.operation == mmhq_pkg::OP_POP_MIN);
          i_nxt      = '0;
          case (in_ch.operation)
            mmhq_pkg::OP_PUSH: begin
              if (full) begin
                status_nxt = mmhq_pkg::STAT_FULL;
              end else begin
                x_nxt    = key;
                i_nxt    = size_r[IDX_W-1:0];
                size_nxt = size_r + CNT_W'(1);
              end
            end
            mmhq_pkg::OP_POP_MIN: begin
              if (empty) status_nxt = mmhq_pkg::STAT_EMPTY;
            end
            mmhq_pkg::OP_POP_MAX: begin
              if (empty) status_nxt = mmhq_pkg::STAT_EMPTY;
              else if (size_r == CNT_W'(2)) i_nxt = IDX_W'(1);
            end
            default: ;
          endcase
        end
      end
      mmhq_pkg::ST_BU_P: begin
        dmin_nxt = bu_minl ^ bu_flip;
        if (bu_flip) i_nxt = IDX_W'((CNT_W'(i_r) - CNT_W'(1)) >> 1);
      end
      mmhq_pkg::ST_BU_GW: begin
        if (gw_move) i_nxt = gp_of_i[IDX_W-1:0];
      end
      mmhq_pkg::ST_PM2: best_val_nxt = rd;
      mmhq_pkg::ST_PM3: begin
        i_nxt      = pm3_pick1 ? IDX_W'(1) : IDX_W'(2);
        popped_nxt = pm3_pick1 ? best_val_r : rd;
      end
      mmhq_pkg::ST_PV:  popped_nxt = rd;
      mmhq_pkg::ST_RM:  size_nxt = size_r - CNT_W'(1);
      mmhq_pkg::ST_RMX: x_nxt = rd;
      mmhq_pkg::ST_SD:  k_nxt = '0;
      mmhq_pkg::ST_SC: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd0) begin
          best_idx_nxt = c_cur;
          best_val_nxt = rd;
          c0_nxt       = rd;
        end else begin
          if (k_r == 3'd1) c1_nxt = rd;
          if (sc_better) begin
            best_idx_nxt = c_cur;
            best_val_nxt = rd;
          end
        end
      end
      mmhq_pkg::ST_SDEC: begin
        if (dec_better) begin
          i_nxt   = best_idx_r[IDX_W-1:0];
          pm_nxt  = pm_w[IDX_W-1:0];
          hpm_nxt = hpm_sel;
        end
      end
      mmhq_pkg::ST_SPM: x_nxt = hpm_r;
      mmhq_pkg::ST_RD0: begin
        mn_nxt = '0;
        mx_nxt = '0;
      end
      mmhq_pkg::ST_RD1: begin
        mn_nxt = rd;
        mx_nxt = rd;
      end
      mmhq_pkg::ST_RD2: mx_nxt = rd;
      mmhq_pkg::ST_RD3: begin
        if ($signed(rd) > $signed(mx_r)) mx_nxt = rd;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mmhq_pkg::ST_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      size_r <= size_nxt;
      if (st_r == mmhq_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    pm_r       <= pm_nxt;
    x_r        <= x_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    hpm_r      <= hpm_nxt;
    popped_r   <= popped_nxt;
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    k_r        <= k_nxt;
    dmin_r     <= dmin_nxt;
    status_r   <= status_nxt;
    if (st_r == mmhq_pkg::ST_FIN && out_free) begin
      out_popped_r <= 32'($signed(popped_r));
      out_status_r <= status_r;
      out_count_r  <= 11'(size_r);
      out_min_r    <= 32'($signed(mn_r));
      out_max_r    <= 32'($signed(mx_r));
    end
  end

  // Drive the result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.popped_value  = out_popped_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.current_min   = out_min_r;
  assign out_ch.current_max   = out_max_r;

`ifndef SYNTHESIS
  // Count never passes capacity
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CNT_W'(CAPACITY))
    else $error("heap count beyond capacity");

  // No memory write while waiting for a transfer
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mmhq_pkg::ST_IDLE) |-> !ram_we)
    else $error("memory write in idle");

  // A new result is loaded only from the finish state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == mmhq_pkg::ST_FIN)
    else $error("result raised outside finish");

  // An accepted item leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> st_r != mmhq_pkg::ST_IDLE)
    else $error("accepted item did not start");
`endif

endmodule

@@ design/mmhq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ test/tb.sv @@
// Testbench for the min-max heap queue: random push/pop traffic checked against a sorted-list predictor.
`timescale 1ns / 100ps

class heap_scoreboard;
  int            key_q[$];
  logic [31:0]   exp_popped[$];
  logic [1:0]    exp_status[$];
  logic [10:0]   exp_count[$];
  logic [31:0]   exp_min[$];
  logic [31:0]   exp_max[$];
  int            errors;
  int            depth_limit;

  function new(int cap);
    depth_limit = cap;
    errors = 0;
  endfunction

  function int pending();
    return exp_status.size();
  endfunction

  // Predict the result of one accepted operation from a sorted copy of the keys.
  function void note_op(logic [1:0] op, logic [31:0] key);
    int signed   keys[$];
    logic [31:0] pv;
    logic [1:0]  st;
    int          pos;
    pv = '0;
    st = mmhq_pkg::STAT_OK;
    keys = key_q;
    if (op == mmhq_pkg::OP_PUSH) begin
      if (keys.size() >= depth_limit) begin
        st = mmhq_pkg::STAT_FULL;
      end else begin
        pos = 0;
        while (pos < keys.size() && keys[pos] < $signed(key)) pos++;
        keys.insert(pos, $signed(key));
      end
    end else if (op == mmhq_pkg::OP_POP_MIN || op == mmhq_pkg::OP_POP_MAX) begin
      if (keys.size() == 0) begin
        st = mmhq_pkg::STAT_EMPTY;
      end else if (op == mmhq_pkg::OP_POP_MIN) begin
        pv = keys.pop_front();
      end else begin
        pv = keys[keys.size()-1];
        keys.delete(keys.size()-1);
      end
    end
    key_q = keys;
    exp_popped.insert(exp_popped.size(), pv);
    exp_status.insert(exp_status.size(), st);
    exp_count.insert(exp_count.size(), 11'(keys.size()));
    exp_min.insert(exp_min.size(), keys.size() ? keys[0] : 32'd0);
    exp_max.insert(exp_max.size(), keys.size() ? keys[keys.size()-1] : 32'd0);
  endfunction

  // Compare one transfer on the result channel with the oldest expectation.
  function void check_result(logic [31:0] pv, logic [1:0] st, logic [10:0] cnt,
                             logic [31:0] mn, logic [31:0] mx);
    logic [31:0] e_pv, e_mn, e_mx;
    logic [1:0]  e_st;
    logic [10:0] e_cnt;
    if (exp_status.size() == 0) begin
      $display("%0t: unexpected result pop=%h st=%0d cnt=%0d", $time, pv, st, cnt);
      errors++;
      return;
    end
    e_pv = exp_popped.pop_front();
    e_st = exp_status.pop_front();
    e_cnt = exp_count.pop_front();
    e_mn = exp_min.pop_front();
    e_mx = exp_max.pop_front();
    if (pv !== e_pv) begin
      $display("%0t: popped_value exp %h got %h", $time, e_pv, pv);
      errors++;
    end
    if (st !== e_st) begin
      $display("%0t: status exp %0d got %0d", $time, e_st, st);
      errors++;
    end
    if (cnt !== e_cnt) begin
      $display("%0t: element_count exp %0d got %0d", $time, e_cnt, cnt);
      errors++;
    end
    if (mn !== e_mn) begin
      $display("%0t: current_min exp %h got %h", $time, e_mn, mn);
      errors++;
    end
    if (mx !== e_mx) begin
      $display("%0t: current_max exp %h got %h", $time, e_mx, mx);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CAP = 1024;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  mmhq_in_if  in_ch();
  mmhq_out_if out_ch();
  heap_scoreboard sb = new(CAP);

  int  cycles = 0;
  bit  idle_enable = 1'b1;
  int  hold_cycles = 0;

  min_max_heap_queue_unit #(.CAPACITY(CAP), .KEY_WIDTH(32)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // Bound the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check each transfer on the result channel.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.popped_value, out_ch.status, out_ch.element_count,
                      out_ch.current_min, out_ch.current_max);
  end

  // Drive ready: random stall bursts, a long hold when requested.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Offer one item and hold it until the transfer.
  task automatic send_op(logic [1:0] op, logic [31:0] key);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.push_value <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_op(op, key);
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly pushes while filling, mostly pops while emptying.
  task automatic random_ops(int count, int push_pct);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) send_op(mmhq_pkg::OP_PUSH, rand_key());
      else if (r < push_pct + (100 - push_pct) / 2) send_op(mmhq_pkg::OP_POP_MIN, 32'd0);
      else if (r < 99) send_op(mmhq_pkg::OP_POP_MAX, 32'd0);
      else send_op(mmhq_pkg::OP_NOP, $urandom);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = mmhq_pkg::OP_PUSH;
    in_ch.push_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pops, extreme keys, small-heap pops, unused code.
    send_op(mmhq_pkg::OP_POP_MIN, 32'd0);
    send_op(mmhq_pkg::OP_POP_MAX, 32'd0);
    send_op(mmhq_pkg::OP_NOP, 32'hffff_ffff);
    send_op(mmhq_pkg::OP_PUSH, 32'h7fff_ffff);
    send_op(mmhq_pkg::OP_POP_MAX, 32'd0);
    send_op(mmhq_pkg::OP_PUSH, 32'h8000_0000);
    send_op(mmhq_pkg::OP_PUSH, 32'h7fff_ffff);
    send_op(mmhq_pkg::OP_POP_MAX, 32'd0);
    send_op(mmhq_pkg::OP_PUSH, 32'd5);
    send_op(mmhq_pkg::OP_PUSH, 32'd5);
    send_op(mmhq_pkg::OP_PUSH, 32'hffff_ffff);
    send_op(mmhq_pkg::OP_POP_MIN, 32'd0);
    send_op(mmhq_pkg::OP_POP_MAX, 32'd0);
    send_op(mmhq_pkg::OP_POP_MIN, 32'd0);
    send_op(mmhq_pkg::OP_POP_MIN, 32'd0);
    send_op(mmhq_pkg::OP_POP_MIN, 32'd0);
    send_op(mmhq_pkg::OP_PUSH, 32'h0000_0000);
    send_op(mmhq_pkg::OP_PUSH, 32'h5555_5555);
    send_op(mmhq_pkg::OP_PUSH, 32'haaaa_aaaa);
    send_op(mmhq_pkg::OP_NOP, 32'd0);

    // Hold off the receiver so the block backs up.
    hold_cycles = 400;
    random_ops(30, 70);
    drain();

    // Random traffic: grow, churn, shrink.
    random_ops(200, 70);
    random_ops(150, 50);
    random_ops(150, 25);
    drain();

    // Back-to-back traffic with no idling on either side.
    idle_enable = 1'b0;
    send_op(mmhq_pkg::OP_PUSH, 32'h8000_0000);
    send_op(mmhq_pkg::OP_PUSH, 32'h7fff_ffff);
    random_ops(198, 50);
    drain();

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
